// ===== rtl/atrf_pkg.sv =====
// Package for the transmit-request framer: frame constants, sequence positions,
// the buffered-item type and the header byte function. No dependencies.
package atrf_pkg;

    localparam int ADDR_W = 64;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 5;

    // Fixed header and trailer bytes.
    localparam logic [BYTE_W-1:0] START_DELIM = 8'h7E;
    localparam logic [BYTE_W-1:0] LEN_HI      = 8'h00;
    localparam logic [BYTE_W-1:0] FRAME_TYPE  = 8'h10;
    localparam logic [BYTE_W-1:0] FRAME_ID    = 8'h01;
    localparam logic [BYTE_W-1:0] NET_ADDR_HI = 8'hFF;
    localparam logic [BYTE_W-1:0] NET_ADDR_LO = 8'hFE;
    localparam logic [BYTE_W-1:0] RADIUS_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] OPT_BYTE    = 8'h00;
    localparam logic [BYTE_W-1:0] LEN_OFFSET  = 8'd14;
    localparam logic [BYTE_W-1:0] CHK_BASE    = 8'hFF;
    // Sum of the fixed bytes covered by the checksum (type, id, 0xFF, 0xFE).
    localparam logic [BYTE_W-1:0] SUM_SEED    = BYTE_W'(17 + 255 + 254);

    // Position of each byte within the emitted sequence of one item.
    localparam logic [IDX_W-1:0] IDX_SOF       = 5'd0;
    localparam logic [IDX_W-1:0] IDX_LEN_HI    = 5'd1;
    localparam logic [IDX_W-1:0] IDX_LEN_LO    = 5'd2;
    localparam logic [IDX_W-1:0] IDX_TYPE      = 5'd3;
    localparam logic [IDX_W-1:0] IDX_ID        = 5'd4;
    localparam logic [IDX_W-1:0] IDX_ADDR_MSB  = 5'd5;
    localparam logic [IDX_W-1:0] IDX_ADDR_LSB  = 5'd12;
    localparam logic [IDX_W-1:0] IDX_NET_HI    = 5'd13;
    localparam logic [IDX_W-1:0] IDX_NET_LO    = 5'd14;
    localparam logic [IDX_W-1:0] IDX_RADIUS    = 5'd15;
    localparam logic [IDX_W-1:0] IDX_OPT       = 5'd16;
    localparam logic [IDX_W-1:0] IDX_DATA      = 5'd17;
    localparam logic [IDX_W-1:0] IDX_CHK       = 5'd18;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] plen;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } t_item;

    // Byte at a given position of the sequence, checksum excluded.
    function automatic logic [BYTE_W-1:0] seq_byte(input logic [IDX_W-1:0] idx,
                                                   input t_item item);
        logic [2:0]        sel;
        logic [BYTE_W-1:0] res;
        sel = 3'(IDX_ADDR_LSB - idx);
        case (idx) inside
            IDX_SOF:                     res = START_DELIM;
            IDX_LEN_HI:                  res = LEN_HI;
            IDX_LEN_LO:                  res = item.plen + LEN_OFFSET;
            IDX_TYPE:                    res = FRAME_TYPE;
            IDX_ID:                      res = FRAME_ID;
            [IDX_ADDR_MSB:IDX_ADDR_LSB]: res = item.addr[{sel, 3'b000} +: BYTE_W];
            IDX_NET_HI:                  res = NET_ADDR_HI;
            IDX_NET_LO:                  res = NET_ADDR_LO;
            IDX_RADIUS:                  res = RADIUS_BYTE;
            IDX_OPT:                     res = OPT_BYTE;
            default:                     res = item.data;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/api_tx_request_framer.sv =====
// Transmit-request framer, top level: item buffer, byte sequencer, checksum
// and output register. Depends on atrf_pkg.
//
// Usage. Payload bytes arrive as beats on the s_axis channel; each beat carries
// the byte, the frame's payload length and a 64-bit destination in tdata, the
// end-of-payload flag on tlast and the start-of-frame and address-select flags
// on tuser. Frame bytes leave one per beat on m_axis; tlast marks the last byte
// caused by an input beat and tuser marks the closing checksum byte.
// The stored destination is written through i_cfg_we / i_cfg_wdata.
//
// Throughput: a frame body streams at one beat per cycle while the receiver
// does not stall. A start-of-frame beat occupies the byte sequencer for its 17
// header bytes and the byte itself, plus the checksum byte when it also ends
// the frame; an end-of-frame beat is followed by the checksum byte. A beat
// outside a frame without the start flag is dropped without output. An accepted
// beat is held in the item buffer; its bytes then leave through the output register.
// Reset clears the buffers, the running checksum, the open-frame flag and the
// stored destination. When the receiver stalls, the output byte is held and the
// input stalls once the single item buffer is occupied.
module api_tx_request_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: [7:0] payload_byte, [15:8] payload_len, [79:16] given_address
    input  logic [79:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    // tuser: [0] first_of_frame, [1] use_given_address
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // tuser: [0] is_checksum
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [atrf_pkg::ADDR_W-1:0] i_cfg_wdata
);
    import atrf_pkg::*;

    // Stored destination address.
    logic [ADDR_W-1:0] r_stored;

    // One buffered input item and its position in the byte sequence.
    t_item             r_item;
    logic              r_item_v;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;

    // Frame state.
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic              r_in_frame;
    logic              n_in_frame;

    // Output register.
    logic              r_out_v;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_chk;

    logic              w_in_acc;
    logic              w_drop;
    logic              w_adv;
    logic              w_emit;
    logic              w_final;
    logic              w_done;
    logic [BYTE_W-1:0] w_byte;
    t_item             w_new_item;

    // A beat with no start flag outside a frame produces nothing.
    assign w_drop  = r_item_v && (r_idx == IDX_DATA) && !r_item.first && !r_in_frame;
    assign w_adv   = r_item_v && (w_drop || !r_out_v || i_m_axis_tready);
    assign w_emit  = w_adv && !w_drop;
    // The data byte is final unless a checksum follows it.
    assign w_final = (r_idx == IDX_CHK) || ((r_idx == IDX_DATA) && !r_item.last);
    assign w_done  = w_adv && (w_drop || w_final);

    assign o_s_axis_tready = !r_item_v || w_done;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_new_item.data  = i_s_axis_tdata[7:0];
    assign w_new_item.plen  = i_s_axis_tdata[15:8];
    assign w_new_item.first = i_s_axis_tuser[0];
    assign w_new_item.last  = i_s_axis_tlast;
    assign w_new_item.addr  = i_s_axis_tuser[1] ? i_s_axis_tdata[79:16] : r_stored;

    always_comb begin
        w_byte     = (r_idx == IDX_CHK) ? (CHK_BASE - r_sum) : seq_byte(r_idx, r_item);
        n_sum      = r_sum;
        n_in_frame = r_in_frame;
        n_idx      = r_idx + 5'd1;
        case (r_idx) inside
            IDX_SOF: begin
                n_sum      = SUM_SEED;
                n_in_frame = 1'b1;
            end
            [IDX_ADDR_MSB:IDX_ADDR_LSB], IDX_DATA: begin
                n_sum = r_sum + w_byte;
            end
            IDX_CHK: begin
                n_sum      = '0;
                n_in_frame = 1'b0;
            end
            default: begin
                n_sum = r_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= '0;
        end else if (i_cfg_we) begin
            r_stored <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_v   <= 1'b0;
            r_idx      <= IDX_SOF;
            r_sum      <= '0;
            r_in_frame <= 1'b0;
        end else begin
            if (w_emit) begin
                r_sum      <= n_sum;
                r_in_frame <= n_in_frame;
            end
            if (w_in_acc) begin
                r_item_v <= 1'b1;
                r_idx    <= i_s_axis_tuser[0] ? IDX_SOF : IDX_DATA;
            end else if (w_done) begin
                r_item_v <= 1'b0;
            end else if (w_emit) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= w_new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_emit) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_final;
            r_out_chk  <= (r_idx == IDX_CHK);
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_chk;

    // The checksum byte always closes the run of its input beat.
    a_chk_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_chk |-> r_out_last)
        else $error("checksum byte without run end");

    // A checksum is only produced for an open frame.
    a_chk_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && (r_idx == IDX_CHK) |-> r_in_frame)
        else $error("checksum outside a frame");

    // Emitting the checksum closes the frame and clears the sum.
    a_chk_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && (r_idx == IDX_CHK) |=> !r_in_frame && (r_sum == '0))
        else $error("frame not closed after checksum");

    // A beat without the start flag never walks through header positions.
    a_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_v && !r_item.first |-> (r_idx == IDX_DATA) || (r_idx == IDX_CHK))
        else $error("header position for a continuation beat");

    // The sequencer never runs past the checksum position.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_v |-> r_idx <= IDX_CHK)
        else $error("sequence position out of range");

endmodule

// ===== dv/tb_api_tx_request_framer.sv =====
// Self-checking testbench for api_tx_request_framer: drives payload beats and destination
// writes, predicts every frame byte and checks the output stream beat by beat.
// Depends on atrf_pkg and the api_tx_request_framer RTL.
module tb_api_tx_request_framer;
    import atrf_pkg::*;

    // One input beat, field by field, and one expected output byte.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] plen;
        logic              first;
        logic              last;
        logic              use_given;
        logic [ADDR_W-1:0] given;
    } t_payload_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              is_chk;
    } t_frame_byte;

    // A directed row either sends a beat or rewrites the stored destination.
    typedef enum logic {ROW_BEAT, ROW_DEST_WRITE} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        t_payload_beat beat;
        int            want_count;  // number of output bytes, -1 when left to the predictor
        int            want_chk;    // checksum byte, -1 when left to the predictor
    } t_stim_row;

    localparam int QUIET_LIMIT = 3000;  // cycles without any beat before the run is abandoned
    localparam int HOLD_CYCLES = 500;   // length of the long receiver hold-off
    localparam int DRAIN_WAIT  = 8;     // settling cycles before a register write
    localparam int TAIL_WAIT   = 40;    // cycles watched for stray bytes at the end

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [79:0]       s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic [1:0]        s_tuser  = '0;
    logic              rx_ready = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata = '0;

    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [7:0]        o_m_axis_tdata;
    logic              o_m_axis_tlast;
    logic              o_m_axis_tuser;

    // Handshake mix of the current phase, in percent of cycles.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          hold_req = 1'b0;

    // Predictor state: the stored destination, the running sum and the open-frame flag.
    logic [ADDR_W-1:0] pred_dest = '0;
    logic [BYTE_W-1:0] pred_sum  = '0;
    logic              pred_open = 1'b0;

    // Frame bytes predicted but not yet seen on the output, oldest first.
    t_frame_byte frame_bytes_due[$];
    t_stim_row   stim_rows[$];

    int err_cnt     = 0;
    int framed_cnt  = 0;
    int stray_cnt   = 0;
    int out_cnt     = 0;
    int dest_writes = 0;
    int quiet_cnt   = 0;

    api_tx_request_framer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Appends one expected byte; the last-of-run flag is set afterwards on the tail.
    function automatic void queue_byte(input logic [BYTE_W-1:0] v, input logic chk);
        t_frame_byte fb;
        fb.out_byte = v;
        fb.run_last = 1'b0;
        fb.is_chk   = chk;
        frame_bytes_due.push_back(fb);
    endfunction

    // Works out the frame bytes that one accepted beat causes and queues them.
    // Returns how many were queued; zero for a byte that arrives outside a frame.
    function automatic int frame_bytes_for(input t_payload_beat b);
        int                base;
        logic [ADDR_W-1:0] dest;
        logic [BYTE_W-1:0] ab;
        base = frame_bytes_due.size();
        if (b.first) begin
            // A start beat always opens a fresh header, even over an unfinished frame.
            dest = b.use_given ? b.given : pred_dest;
            queue_byte(START_DELIM, 1'b0);
            queue_byte(LEN_HI, 1'b0);
            queue_byte(b.plen + LEN_OFFSET, 1'b0);  // wraps modulo 256
            queue_byte(FRAME_TYPE, 1'b0);
            queue_byte(FRAME_ID, 1'b0);
            pred_sum = FRAME_TYPE + FRAME_ID + NET_ADDR_HI + NET_ADDR_LO;
            for (int i = 7; i >= 0; i--) begin
                ab = dest[8*i +: 8];
                pred_sum = pred_sum + ab;
                queue_byte(ab, 1'b0);
            end
            queue_byte(NET_ADDR_HI, 1'b0);
            queue_byte(NET_ADDR_LO, 1'b0);
            queue_byte(RADIUS_BYTE, 1'b0);
            queue_byte(OPT_BYTE, 1'b0);
            pred_open = 1'b1;
        end else if (!pred_open) begin
            return 0;
        end
        pred_sum = pred_sum + b.data;
        queue_byte(b.data, 1'b0);
        if (b.last) begin
            queue_byte(CHK_BASE - pred_sum, 1'b1);
            pred_open = 1'b0;
            pred_sum  = '0;
        end
        frame_bytes_due[frame_bytes_due.size()-1].run_last = 1'b1;
        return frame_bytes_due.size() - base;
    endfunction

    // Offers one beat after the sender's random idle cycles and waits for the handshake.
    // tvalid is left high on return, so a following beat can go out back to back.
    task automatic send_beat(input t_payload_beat b, output int n_bytes);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.given, b.plen, b.data};
        s_tlast  <= b.last;
        s_tuser  <= {b.use_given, b.first};
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_bytes = frame_bytes_for(b);
        if (n_bytes > 0)
            framed_cnt++;
        else
            stray_cnt++;
    endtask

    // Rewrites the stored destination once the output has drained and the block is idle.
    task automatic write_dest(input logic [ADDR_W-1:0] val);
        s_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        pred_dest = val;
        dest_writes++;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [7:0] data, input logic [7:0] plen,
                           input logic first, input logic last, input logic use_given,
                           input logic [ADDR_W-1:0] given, input int want_count,
                           input int want_chk);
        t_stim_row r;
        r.kind = kind;
        r.beat = '{data, plen, first, last, use_given, given};
        r.want_count = want_count;
        r.want_chk   = want_chk;
        stim_rows.push_back(r);
    endtask

    // Random frames with random content until the requested number of beats has
    // produced output. Most frames are well formed; some are cut short so that the
    // next start beat abandons them, some lie about their length, and a few stray
    // bytes without a start flag are mixed in.
    task automatic run_frames(input int target);
        int            got;
        int            len;
        int            sent;
        int            n;
        int            r;
        logic [7:0]    plen;
        t_payload_beat b;
        got = 0;
        while (got < target) begin
            r = $urandom_range(99);
            if (r < 8) begin
                b = '{8'($urandom), 8'($urandom), 1'b0, 1'($urandom), 1'($urandom),
                      {$urandom, $urandom}};
                send_beat(b, n);
                if (n > 0) got++;
            end else begin
                r = $urandom_range(99);
                if (r < 80)      len = $urandom_range(1, 8);
                else if (r < 95) len = $urandom_range(9, 30);
                else             len = $urandom_range(31, 60);
                plen = ($urandom_range(99) < 85) ? 8'(len) : 8'($urandom);
                sent = ($urandom_range(99) < 10) ? $urandom_range(0, len - 1) : len;
                for (int i = 0; i < sent; i++) begin
                    // Length, select and address only count on the start beat, so
                    // later beats carry random values there.
                    b.data      = 8'($urandom);
                    b.plen      = (i == 0) ? plen : 8'($urandom);
                    b.first     = (i == 0);
                    b.last      = (i == len - 1);
                    b.use_given = 1'($urandom);
                    b.given     = {$urandom, $urandom};
                    send_beat(b, n);
                    if (n > 0) got++;
                end
            end
        end
    endtask

    // Receiver: stalls at the phase's rate, or holds off for one long stretch on request.
    initial begin : rx_side
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Output checker: every accepted byte is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && o_m_axis_tvalid && rx_ready) begin
            out_cnt++;
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected output beat: out_byte %02h run_last %0b is_checksum %0b",
                       o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                err_cnt++;
            end else begin
                want = frame_bytes_due.pop_front();
                if (o_m_axis_tdata !== want.out_byte) begin
                    $error("out_byte: expected %02h, actual %02h (output beat %0d)",
                           want.out_byte, o_m_axis_tdata, out_cnt);
                    err_cnt++;
                end
                if (o_m_axis_tlast !== want.run_last) begin
                    $error("run_last: expected %0b, actual %0b (output beat %0d)",
                           want.run_last, o_m_axis_tlast, out_cnt);
                    err_cnt++;
                end
                if (o_m_axis_tuser !== want.is_chk) begin
                    $error("is_checksum: expected %0b, actual %0b (output beat %0d)",
                           want.is_chk, o_m_axis_tuser, out_cnt);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: a long stretch without any beat on either side means the block has hung.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && rx_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int            n;
        t_stim_row     row;
        t_payload_beat b;

        // Directed rows. Counts are given for every row; checksums only where they
        // follow at once from an all-zero or all-ones frame.
        // Straight after reset the stored destination is zero.
        add_row(ROW_BEAT, 8'h00, 8'd1,   1, 1, 0, 64'h0, 19, 8'hF1);
        // Bytes outside a frame are dropped, with or without the end flag.
        add_row(ROW_BEAT, 8'h55, 8'd7,   0, 0, 1, 64'h0, 0, -1);
        add_row(ROW_BEAT, 8'hAA, 8'd7,   0, 1, 0, 64'h0, 0, -1);
        // Longest legal frame length with an all-ones given address.
        add_row(ROW_BEAT, 8'hFF, 8'd241, 1, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 18, -1);
        add_row(ROW_BEAT, 8'h00, 8'd0,   0, 0, 0, 64'h0, 1, -1);
        add_row(ROW_BEAT, 8'hFF, 8'd255, 0, 0, 1, 64'h0, 1, -1);
        add_row(ROW_BEAT, 8'h80, 8'd3,   0, 1, 0, 64'h0, 2, -1);
        // Length byte wrapping past 255.
        add_row(ROW_BEAT, 8'h3C, 8'd242, 1, 0, 0, 64'h0, 18, -1);
        // A start beat inside an open frame, with an out-of-range length of zero.
        add_row(ROW_BEAT, 8'hC3, 8'd0,   1, 0, 1, 64'h0123_4567_89AB_CDEF, 18, -1);
        add_row(ROW_BEAT, 8'hAA, 8'd0,   0, 1, 0, 64'h0, 2, -1);
        add_row(ROW_DEST_WRITE, 8'h00, 8'd0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, -1);
        // Start and end together: the stored all-ones address, then a given zero one.
        add_row(ROW_BEAT, 8'hFF, 8'd255, 1, 1, 0, 64'h0, 19, 8'hFA);
        add_row(ROW_BEAT, 8'h00, 8'd1,   1, 1, 1, 64'h0, 19, 8'hF1);
        add_row(ROW_DEST_WRITE, 8'h00, 8'd0, 0, 0, 0, 64'hA5A5_5A5A_0F0F_F0F0, 0, -1);
        add_row(ROW_BEAT, 8'h01, 8'd3,   1, 0, 0, 64'hFFFF_0000_FFFF_0000, 18, -1);
        add_row(ROW_BEAT, 8'h7F, 8'hFF,  0, 0, 1, 64'hDEAD_BEEF_CAFE_F00D, 1, -1);
        add_row(ROW_BEAT, 8'hFE, 8'd9,   0, 1, 1, 64'h0, 2, -1);
        add_row(ROW_DEST_WRITE, 8'h00, 8'd0, 0, 0, 0, 64'h0, 0, -1);
        add_row(ROW_BEAT, 8'h00, 8'd1,   1, 1, 0, 64'h0, 19, 8'hF1);
        add_row(ROW_BEAT, 8'h12, 8'd5,   0, 1, 1, 64'h0, 0, -1);

        // Reset is held low from time zero and released on a rising edge.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with no idling on either side.
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.kind == ROW_DEST_WRITE) begin
                write_dest(row.beat.given);
            end else begin
                send_beat(row.beat, n);
                if (row.want_count >= 0 && n != row.want_count) begin
                    $error("byte count of directed row %0d: expected %0d, actual %0d",
                           k, row.want_count, n);
                    err_cnt++;
                end
                // The hand-worked checksum replaces the predicted one for this row.
                if (row.want_chk >= 0 && n > 0)
                    frame_bytes_due[frame_bytes_due.size()-1].out_byte = 8'(row.want_chk);
            end
        end

        // Random phases, each with a fresh stored destination and its own handshake mix.
        for (int ph = 0; ph < 4; ph++) begin
            write_dest({$urandom, $urandom});
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            run_frames(25);
        end

        // Long hold-off: the receiver stops while the sender keeps offering one long
        // frame, so the item buffer fills and the input stalls.
        write_dest({$urandom, $urandom});
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        for (int i = 0; i < 30; i++) begin
            b = '{8'($urandom), (i == 0) ? 8'd30 : 8'($urandom), (i == 0), (i == 29),
                  1'($urandom), {$urandom, $urandom}};
            send_beat(b, n);
        end

        // Drain, then watch a while longer for any byte nobody asked for.
        s_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Covered %0d framed beats, %0d dropped stray beats and %0d output bytes,",
                 framed_cnt, stray_cnt, out_cnt);
        $display("with %0d destination writes, four handshake mixes and one long hold-off.",
                 dest_writes);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
